>>> design/sobel_edge_magnitude_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Sobel edge magnitude block
// Clocked property wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define SEM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// property checked on every edge, reset included
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SEM_ASSERT(lbl, clk, rstn, prop, msg)
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/sem_pkg.sv
// ---------------------------------------------------------------------------
// sem_pkg
// Shared constants and types of the Sobel edge magnitude block.
// ---------------------------------------------------------------------------
package sem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIXEL_W     = CHAN_W * NUM_CHAN;
  localparam int GRAD_W      = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CHAN_W-1:0] EDGE_CAP = 8'd255;
  // 255.5^2 rounded down: anything above rounds to at least 256
  localparam logic [20:0] SUM_LIMIT = 21'd65280;

  typedef struct packed {
    logic [NUM_CHAN-1:0][GRAD_W-1:0] gx;
    logic [NUM_CHAN-1:0][GRAD_W-1:0] gy;
    logic                            last;
  } grad_entry_t;

endpackage

>>> design/sem_ram.sv
// ---------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sem_queue.sv
// ---------------------------------------------------------------------------
// sem_queue
// Short FIFO of gradient entries between the window front and the root back.
// ---------------------------------------------------------------------------
module sem_queue #(
  parameter int DEPTH = sem_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sem_pkg::grad_entry_t push_data,
  output logic                 full,
  input  logic                 pop,
  output sem_pkg::grad_entry_t pop_data,
  output logic                 empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sem_pkg::grad_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> design/sem_front.sv
// ---------------------------------------------------------------------------
// sem_front
// Pixel intake: frame position, two line stores, 3x3 window and the Sobel
// Gx/Gy sums. Pushes one gradient entry per emitted result.
// ---------------------------------------------------------------------------
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [sem_pkg::CHAN_W-1:0]         in_pixel_blue,
  input  logic [sem_pkg::CHAN_W-1:0]         in_pixel_green,
  input  logic [sem_pkg::CHAN_W-1:0]         in_pixel_red,
  input  logic                               in_flush,
  input  logic                               cfg_we,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               q_push,
  output sem_pkg::grad_entry_t               q_entry,
  input  logic                               q_full
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SWW = $clog2(MAX_WIDTH + 1);
  localparam int SHW = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int PW  = sem_pkg::PIXEL_W;
  localparam int GW  = sem_pkg::GRAD_W;

  typedef enum logic {S_IDLE, S_CALC} state_t;

  function automatic logic [31:0] clamp_size(input logic [sem_pkg::CFG_DATA_W-1:0] v,
                                             input int max_v);
    logic [31:0] r;
    r = 32'(v);
    if (r == 32'd0) begin
      r = 32'd1;
    end else if (r > 32'(max_v)) begin
      r = 32'(max_v);
    end
    return r;
  endfunction

  // weighted first triple minus weighted second triple: right minus left column for Gx, bottom minus top row for Gy
  function automatic logic [GW-1:0] weigh(input logic [7:0] p0, p1, p2, n0, n1, n2);
    return GW'(p0) + (GW'(p1) << 1) + GW'(p2) - GW'(n0) - (GW'(n1) << 1) - GW'(n2);
  endfunction

  state_t        state_r;
  logic [SWW-1:0] width_r;
  logic [SHW-1:0] height_r;
  logic [RW-1:0]  in_row_r, out_row_r;
  logic [CW-1:0]  in_col_r, out_col_r;
  logic [PW-1:0]  sample_r;
  logic [PW-1:0]  win_r [3][3];   // [column][row], column 2 newest, row 0 top

  logic [PW-1:0] above_q, two_above_q;
  logic [PW-1:0] top_px, mid_px, bot_px;
  logic [PW-1:0] nb_l [3], nb_m [3], nb_r [3];
  logic          accept, ignore_flush, emit, last, left_ok, wrap;
  logic [31:0]   ir, ic, w, h;
  sem_pkg::grad_entry_t entry;

  assign in_full      = (state_r != S_IDLE) || q_full;
  assign accept       = in_push && !in_full;
  assign ignore_flush = in_flush && (in_row_r == '0) && (in_col_r == '0);

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (state_r == S_CALC),
    .waddr (in_col_r),
    .wdata (bot_px),
    .raddr (in_col_r),
    .rdata (above_q)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (state_r == S_CALC),
    .waddr (in_col_r),
    .wdata (mid_px),
    .raddr (in_col_r),
    .rdata (two_above_q)
  );

  always_comb begin
    ir = 32'(in_row_r);
    ic = 32'(in_col_r);
    w  = 32'(width_r);
    h  = 32'(height_r);

    top_px = (ir >= 32'd2 && ir < h + 32'd2) ? two_above_q : '0;
    mid_px = (ir >= 32'd1 && ir < h + 32'd1) ? above_q : '0;
    bot_px = (ir < h) ? sample_r : '0;

    emit = (ir >= 32'd2) || (ir == 32'd1 && ic >= 32'd1);
    wrap = (ic + 32'd1 >= w);
    last = emit && (32'(out_row_r) >= h - 32'd1) && (32'(out_col_r) >= w - 32'd1);

    // at column 0 the centre is the previous row's last pixel
    left_ok = (ic == 32'd0) ? (w >= 32'd2) : (ic >= 32'd2);
    for (int r = 0; r < 3; r++) begin
      nb_l[r] = left_ok ? win_r[1][r] : '0;
      nb_m[r] = win_r[2][r];
    end
    nb_r[0] = (ic == 32'd0) ? '0 : top_px;
    nb_r[1] = (ic == 32'd0) ? '0 : mid_px;
    nb_r[2] = (ic == 32'd0) ? '0 : bot_px;

    for (int c = 0; c < sem_pkg::NUM_CHAN; c++) begin
      entry.gx[c] = weigh(nb_r[0][8*c +: 8], nb_r[1][8*c +: 8], nb_r[2][8*c +: 8],
                          nb_l[0][8*c +: 8], nb_l[1][8*c +: 8], nb_l[2][8*c +: 8]);
      entry.gy[c] = weigh(nb_l[2][8*c +: 8], nb_m[2][8*c +: 8], nb_r[2][8*c +: 8],
                          nb_l[0][8*c +: 8], nb_m[0][8*c +: 8], nb_r[0][8*c +: 8]);
    end
    entry.last = last;
  end

  assign q_push  = (state_r == S_CALC) && emit;
  assign q_entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      width_r   <= SWW'(clamp_size(sem_pkg::CFG_DATA_W'(sem_pkg::RESET_WIDTH), MAX_WIDTH));
      height_r  <= SHW'(clamp_size(sem_pkg::CFG_DATA_W'(sem_pkg::RESET_HEIGHT), MAX_HEIGHT));
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[k][r] <= '0;
        end
      end
    end else if (cfg_we && (cfg_index == sem_pkg::REG_IMAGE_WIDTH ||
                            cfg_index == sem_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg_index == sem_pkg::REG_IMAGE_WIDTH) begin
        width_r <= SWW'(clamp_size(cfg_wdata, MAX_WIDTH));
      end else begin
        height_r <= SHW'(clamp_size(cfg_wdata, MAX_HEIGHT));
      end
      state_r   <= S_IDLE;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[k][r] <= '0;
        end
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && !ignore_flush) begin
            sample_r <= in_flush ? '0 : {in_pixel_red, in_pixel_green, in_pixel_blue};
            state_r  <= S_CALC;
          end
        end
        S_CALC: begin
          state_r <= S_IDLE;
          if (last) begin
            in_row_r  <= '0;
            in_col_r  <= '0;
            out_row_r <= '0;
            out_col_r <= '0;
            for (int k = 0; k < 3; k++) begin
              for (int r = 0; r < 3; r++) begin
                win_r[k][r] <= '0;
              end
            end
          end else begin
            for (int r = 0; r < 3; r++) begin
              win_r[0][r] <= win_r[1][r];
              win_r[1][r] <= win_r[2][r];
            end
            win_r[2][0] <= top_px;
            win_r[2][1] <= mid_px;
            win_r[2][2] <= bot_px;
            if (wrap) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + 1'b1;
            end else begin
              in_col_r <= in_col_r + 1'b1;
            end
            if (emit) begin
              if (32'(out_col_r) + 32'd1 >= w) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/sem_back.sv
// ---------------------------------------------------------------------------
// sem_back
// Magnitude unit: squares Gx and Gy, then a digit-by-digit square root with
// rounding and capping, three channels side by side, into the output register.
// ---------------------------------------------------------------------------
module sem_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  sem_pkg::grad_entry_t       q_entry,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [sem_pkg::CHAN_W-1:0] out_edge_blue,
  output logic [sem_pkg::CHAN_W-1:0] out_edge_green,
  output logic [sem_pkg::CHAN_W-1:0] out_edge_red,
  output logic                       out_frame_last
);

  localparam int NC = sem_pkg::NUM_CHAN;
  localparam int GW = sem_pkg::GRAD_W;

  typedef enum logic [2:0] {B_IDLE, B_SQUARE, B_SUM, B_ROOT, B_FINISH} state_t;

  state_t      state_r;
  logic [2:0]  cnt_r;
  logic        last_r, out_valid_r;
  logic [GW-1:0] gx_r [NC], gy_r [NC];
  logic [19:0] sqx_r [NC], sqy_r [NC];
  logic [15:0] op_r [NC];
  logic [16:0] res_r [NC];
  logic        cap_r [NC];
  logic [sem_pkg::CHAN_W-1:0] edge_r [NC];

  logic signed [21:0] px [NC], py [NC];
  logic [20:0] sum [NC];
  logic [16:0] one, trial [NC];
  logic [7:0]  mag [NC];
  logic        take;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign take      = !out_valid_r || out_pop;
  assign one       = 17'd1 << {3'd7 - cnt_r, 1'b0};

  always_comb begin
    for (int l = 0; l < NC; l++) begin
      px[l]    = $signed({{11{gx_r[l][GW-1]}}, gx_r[l]}) * $signed({{11{gx_r[l][GW-1]}}, gx_r[l]});
      py[l]    = $signed({{11{gy_r[l][GW-1]}}, gy_r[l]}) * $signed({{11{gy_r[l][GW-1]}}, gy_r[l]});
      sum[l]   = 21'(sqx_r[l]) + 21'(sqy_r[l]);
      trial[l] = res_r[l] + one;
      // round up when the remainder exceeds the root
      if (cap_r[l] || (17'(op_r[l]) > res_r[l] && res_r[l][7:0] == sem_pkg::EDGE_CAP)) begin
        mag[l] = sem_pkg::EDGE_CAP;
      end else if (17'(op_r[l]) > res_r[l]) begin
        mag[l] = res_r[l][7:0] + 8'd1;
      end else begin
        mag[l] = res_r[l][7:0];
      end
    end
  end

  assign out_edge_blue  = edge_r[0];
  assign out_edge_green = edge_r[1];
  assign out_edge_red   = edge_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps the register full
      if (out_pop && out_valid_r && state_r != B_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            for (int l = 0; l < NC; l++) begin
              gx_r[l] <= q_entry.gx[l];
              gy_r[l] <= q_entry.gy[l];
            end
            last_r  <= q_entry.last;
            state_r <= B_SQUARE;
          end
        end
        B_SQUARE: begin
          for (int l = 0; l < NC; l++) begin
            sqx_r[l] <= px[l][19:0];
            sqy_r[l] <= py[l][19:0];
          end
          state_r <= B_SUM;
        end
        B_SUM: begin
          for (int l = 0; l < NC; l++) begin
            op_r[l]  <= sum[l][15:0];
            cap_r[l] <= sum[l] > sem_pkg::SUM_LIMIT;
            res_r[l] <= '0;
          end
          cnt_r   <= '0;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          for (int l = 0; l < NC; l++) begin
            if (17'(op_r[l]) >= trial[l]) begin
              op_r[l]  <= op_r[l] - trial[l][15:0];
              res_r[l] <= (res_r[l] >> 1) + one;
            end else begin
              res_r[l] <= res_r[l] >> 1;
            end
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 3'd7) begin
            state_r <= B_FINISH;
          end
        end
        B_FINISH: begin
          if (take) begin
            for (int l = 0; l < NC; l++) begin
              edge_r[l] <= mag[l];
            end
            out_frame_last <= last_r;
            out_valid_r    <= 1'b1;
            state_r        <= B_IDLE;
          end else if (out_pop && out_valid_r) begin
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> design/sobel_edge_magnitude.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// ---------------------------------------------------------------------------
// Pixels enter through a queue-style push/full port; results leave through
// empty/pop, one per pixel, lagging by one row plus one pixel, so after a
// frame's last pixel send image_width+1 flush items to drain it. Each
// channel result is round(sqrt(gx^2+gy^2)) capped at 255, with pixels outside
// the frame taken as zero; frame_last marks the final result of a frame. The
// intake takes an item, then updates the window and forms Gx/Gy from the
// registered line-store reads before taking the next. The magnitude unit runs
// square, sum, 8-step square root and output handoff and takes no new entry
// until its result is handed off; a 4-entry gradient queue lets the intake
// run ahead. The line stores need no clearing after reset. Writing image_width
// or image_height restarts the frame; write only while the block is idle.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [sem_pkg::CHAN_W-1:0]      in_pixel_blue,
  input  logic [sem_pkg::CHAN_W-1:0]      in_pixel_green,
  input  logic [sem_pkg::CHAN_W-1:0]      in_pixel_red,
  input  logic                            in_flush,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [sem_pkg::CHAN_W-1:0]      out_edge_blue,
  output logic [sem_pkg::CHAN_W-1:0]      out_edge_green,
  output logic [sem_pkg::CHAN_W-1:0]      out_edge_red,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "sobel_edge_magnitude_assert.svh"

  logic                 q_push, q_full, q_pop, q_empty;
  sem_pkg::grad_entry_t q_in, q_out;

  assign cfg_ready = 1'b1;

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .in_flush       (in_flush),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_push         (q_push),
    .q_entry        (q_in),
    .q_full         (q_full)
  );

  sem_queue #(.DEPTH(sem_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sem_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_entry        (q_out),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_edge_blue  (out_edge_blue),
    .out_edge_green (out_edge_green),
    .out_edge_red   (out_edge_red),
    .out_frame_last (out_frame_last)
  );

  // an entry is only produced after a pixel was taken with room in the queue
  `SEM_ASSERT(a_no_push_when_full, clk, rst_n, q_push |-> !q_full, "gradient push while queue full")
  `SEM_ASSERT(a_no_pop_when_empty, clk, rst_n, q_pop |-> !q_empty, "gradient pop while queue empty")
  `SEM_ASSERT(a_full_while_busy, clk, rst_n, q_push |-> in_full, "intake open during gradient push")
  `SEM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty, "result pending after reset")

endmodule

>>> bench/sobel_edge_magnitude_test.sv
// ---------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams RGB frames of many sizes through the block, predicts every edge
// result from a behavioral copy of the line stores and 3x3 window, and checks
// each popped result in order under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;
  localparam int EXTREME_ITEMS  = 48;
  localparam int ITEMS_TOTAL    = 1400;
  localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push, in_full, in_flush;
  logic [CHAN_W-1:0] in_pixel_blue, in_pixel_green, in_pixel_red;
  logic out_empty, out_pop, out_frame_last;
  logic [CHAN_W-1:0] out_edge_blue, out_edge_green, out_edge_red;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sobel_edge_magnitude uut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [PIXEL_W-1:0] row_one[MAX_W];
  logic [PIXEL_W-1:0] row_two[MAX_W];
  logic [PIXEL_W-1:0] win[9];
  int frame_w = RESET_WIDTH, frame_h = RESET_HEIGHT;
  int row_in, col_in, row_out, col_out;
  edge_result_t expected_edges[$];

  int tx_idle_pct, rx_stall_pct;
  int items_sent, mismatches, idle_cycles, hold_left;
  bit hold_start;
  edge_result_t want;

  function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int max);
    if (v == 0) return 1;
    if (v > max) return max;
    return v;
  endfunction

  function automatic logic [7:0] round_sqrt(input int s);
    int n;
    n = 0;
    if (s > 65280) return EDGE_CAP;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? EDGE_CAP : n[7:0];
  endfunction

  function automatic void restart_frame();
    foreach (win[k]) win[k] = '0;
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
  endfunction

  // advance the predictor by one accepted item
  function automatic void predict_edges(input bit flush, input logic [PIXEL_W-1:0] pix);
    int ir, ic, centre, gx, gy, v;
    logic [PIXEL_W-1:0] top, mid, bot;
    logic [PIXEL_W-1:0] nb[9];
    logic [7:0] mag[3];
    bit emit;
    edge_result_t r;
    ir = row_in; ic = col_in;
    if (flush && ir == 0 && ic == 0) return;  // idle flush
    if (ic >= frame_w) ic = 0;
    top = (ir >= 2 && ir - 2 < frame_h) ? row_two[ic] : '0;
    mid = (ir >= 1 && ir - 1 < frame_h) ? row_one[ic] : '0;
    bot = (ir < frame_h && !flush) ? pix : '0;
    row_two[ic] = mid;
    row_one[ic] = bot;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = bot;
    emit = ir >= 2 || (ir == 1 && ic >= 1);
    centre = ic;
    ic++;
    if (ic >= frame_w) begin
      ic = 0;
      ir++;
    end
    row_in = ir; col_in = ic;
    if (!emit) return;
    for (int k = 0; k < 3; k++) begin
      if (centre == 0) begin
        // centre sits in the last column of the previous row
        nb[k*3] = (frame_w >= 2) ? win[k*3] : '0;
        nb[k*3+2] = '0;
      end else begin
        nb[k*3] = (centre >= 2) ? win[k*3] : '0;
        nb[k*3+2] = win[k*3+2];
      end
      nb[k*3+1] = win[k*3+1];
    end
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0; gy = 0;
      for (int k = 0; k < 9; k++) begin
        v = (nb[k] >> (8 * ch)) & 8'hFF;
        gx += v * KX[k];
        gy += v * KY[k];
      end
      mag[ch] = round_sqrt(gx * gx + gy * gy);
    end
    r.blue = mag[0]; r.green = mag[1]; r.red = mag[2];
    if (row_out >= frame_h - 1 && col_out >= frame_w - 1) begin
      r.last = 1'b1;
      restart_frame();
    end else begin
      r.last = 1'b0;
      col_out++;
      if (col_out >= frame_w) begin
        col_out = 0;
        row_out++;
      end
    end
    expected_edges.push_back(r);
  endfunction

  // push stays high after a transfer so back-to-back items need no toggle
  task automatic send_item(input bit flush, input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_flush <= flush;
    in_pixel_blue <= pix[7:0];
    in_pixel_green <= pix[15:8];
    in_pixel_red <= pix[23:16];
    do @(posedge clk); while (in_full);
    predict_edges(flush, pix);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) frame_w = clamp_size(val, MAX_W);
    else frame_h = clamp_size(val, MAX_H);
    restart_frame();
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // one frame plus its drain; with noise, in-frame flushes and drain pixels
  task automatic send_frame(input bit noise);
    for (int i = 0; i < frame_w * frame_h; i++)
      send_item(noise && i != 0 && $urandom_range(9) == 0, PIXEL_W'($urandom));
    for (int i = 0; i <= frame_w; i++)
      send_item(!(noise && $urandom_range(2) == 0), PIXEL_W'($urandom));
    if (noise && $urandom_range(3) == 0) send_item(1'b1, PIXEL_W'($urandom));
  endtask

  task automatic test_directed();
    tx_idle_pct = 0; rx_stall_pct = 0;
    set_size(3, 3);
    send_item(1'b1, '0);  // flush before any pixel: ignored
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h000000);
    send_item(1'b1, 24'hFFFFFF);  // flush inside the frame reads as zero
    send_item(1'b0, 24'hFF00FF);
    send_item(1'b0, 24'h00FF00);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b0, 24'h123456);
    send_item(1'b0, 24'hABCDEF);  // pixel while draining acts as a flush
    send_item(1'b1, '0);
    send_item(1'b1, '0);
    send_item(1'b1, '0);
    set_size(1, 1);
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b1, '0);
    send_item(1'b0, 24'h55AA55);
  endtask

  // out-of-range sizes; the huge frames are only started, then cut by a write
  task automatic test_size_extremes();
    tx_idle_pct = 0; rx_stall_pct = 0;
    set_size(0, 0);  // reads as 1 x 1
    send_frame(1'b1);
    set_size(0, 11'h7FF);  // reads as 1 x MAX_H
    for (int i = 0; i < EXTREME_ITEMS; i++)
      send_item(1'b0, PIXEL_W'($urandom));
    set_size(11'h7FF, 0);  // reads as MAX_W x 1
    for (int i = 0; i < EXTREME_ITEMS; i++)
      send_item(1'b0, PIXEL_W'($urandom));
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0; rx_stall_pct = 0;
    set_size(6, 5);
    hold_start = 1'b1;
    send_frame(1'b0);
  endtask

  task automatic test_random_frames();
    int phase;
    phase = 0;
    while (items_sent < ITEMS_TOTAL) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      phase++;
      set_size($urandom_range(1, 9), $urandom_range(1, 6));
      send_frame($urandom_range(3) != 0);
    end
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_pop && !out_empty) begin
        if (expected_edges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = expected_edges.pop_front();
          if (out_edge_blue !== want.blue || out_edge_green !== want.green ||
              out_edge_red !== want.red || out_frame_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp b=%0d g=%0d r=%0d last=%0b got b=%0d g=%0d r=%0d last=%0b",
                       $realtime, want.blue, want.green, want.red, want.last,
                       out_edge_blue, out_edge_green, out_edge_red, out_frame_last);
          end
        end
      end
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_flush <= 1'b0;
    in_pixel_blue <= '0;
    in_pixel_green <= '0;
    in_pixel_red <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    restart_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/sem_pkg.sv
design/sem_ram.sv
design/sem_queue.sv
design/sem_front.sv
design/sem_back.sv
design/sobel_edge_magnitude.sv
bench/sobel_edge_magnitude_test.sv
